// File: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, quiet while reset is high
`define CHK_ON(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also runs through reset
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/tcp_pkg.sv
// types and constants of the tissue class to probabilities core
package tcp_pkg;

  localparam int INTENSITY_BITS_DEF = 16;
  localparam int MEAN_W             = 16;
  localparam int OFS_W              = 8;
  localparam int CFG_W              = MEAN_W;
  localparam int CLS_W              = 3;
  localparam int PROB_W             = 8;
  localparam int PROB_MAX           = (1 << PROB_W) - 1;
  localparam int PAIR_SCALE         = 2 * PROB_MAX;
  // signed difference of two means
  localparam int DEN_W              = MEAN_W + 2;
  // divisor is 2*d
  localparam int DIVR_W             = MEAN_W + 1;
  // dividend 510*n + d stays below 2^(MEAN_W+9)
  localparam int REM_W              = MEAN_W + PROB_W + 1;
  localparam int BITS_PER_STAGE     = 2;
  localparam int DIV_STAGES         = PROB_W / BITS_PER_STAGE;

  localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(PROB_MAX);

  typedef enum logic [CLS_W-1:0] {
    CLS_BG     = 3'd0,
    CLS_CSF_BG = 3'd1,
    CLS_CSF    = 3'd2,
    CLS_GM_CSF = 3'd3,
    CLS_GM     = 3'd4,
    CLS_WM_GM  = 3'd5,
    CLS_WM     = 3'd6,
    CLS_BG_ALT = 3'd7
  } tissue_cls_t;

  typedef enum logic [1:0] {
    REG_MEAN_CSF  = 2'd0,
    REG_MEAN_GM   = 2'd1,
    REG_MEAN_WM   = 2'd2,
    REG_LABEL_OFS = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    IDX_CSF = 2'd0,
    IDX_GM  = 2'd1,
    IDX_WM  = 2'd2
  } tissue_idx_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean_csf;
    logic [MEAN_W-1:0] mean_gm;
    logic [MEAN_W-1:0] mean_wm;
    logic [OFS_W-1:0]  label_offset;
  } cfg_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [PROB_W-1:0] quot;
  } div_lane_t;

  typedef struct packed {
    logic              valid;
    tissue_cls_t       cls;
    logic [DIVR_W-1:0] divisor;
    div_lane_t         lo;
    div_lane_t         hi;
  } div_stage_t;

  typedef struct packed {
    logic              valid;
    logic [PROB_W-1:0] csf_prob;
    logic [PROB_W-1:0] gm_prob;
    logic [PROB_W-1:0] wm_prob;
    logic [OFS_W-1:0]  tissue_label;
  } result_t;

endpackage

// File: rtl/tcp_stream_if.sv
// voxel and probability stream interfaces
interface tcp_in_if import tcp_pkg::*; #(
  parameter int INTENSITY_BITS = INTENSITY_BITS_DEF
) ();
  logic                      valid;
  logic                      ready;
  logic [CLS_W-1:0]          tissue_class;
  logic [INTENSITY_BITS-1:0] intensity;

  modport source (output valid, tissue_class, intensity, input ready);
  modport sink   (input valid, tissue_class, intensity, output ready);
endinterface

interface tcp_out_if import tcp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PROB_W-1:0] csf_prob;
  logic [PROB_W-1:0] gm_prob;
  logic [PROB_W-1:0] wm_prob;
  logic [OFS_W-1:0]  tissue_label;

  modport source (output valid, csf_prob, gm_prob, wm_prob, tissue_label, input ready);
  modport sink   (input valid, csf_prob, gm_prob, wm_prob, tissue_label, output ready);
endinterface

// File: rtl/tcp_prep.sv
// operand stages: fraction terms, sign fix and clamp, dividend build
module tcp_prep import tcp_pkg::*; #(
  parameter int INTENSITY_BITS = INTENSITY_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [CLS_W-1:0]          tissue_class,
  input  logic [INTENSITY_BITS-1:0] intensity,
  input  cfg_t                      cfg,
  output div_stage_t                out_stage
);

  localparam int NUM_W = ((INTENSITY_BITS > MEAN_W) ? INTENSITY_BITS : MEAN_W) + 3;

  typedef struct packed {
    logic             valid;
    tissue_cls_t      cls;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } frac_t;

  typedef struct packed {
    logic              valid;
    tissue_cls_t       cls;
    logic [MEAN_W-1:0] n;
    logic [MEAN_W-1:0] d;
  } mag_t;

  frac_t            frac, frac_next;
  mag_t             mag, mag_next;
  div_stage_t       out_next;
  logic [NUM_W-1:0] x_ext;
  logic [NUM_W-1:0] num_abs;
  logic [DEN_W-1:0] den_abs;
  logic [NUM_W-1:0] den_ext;
  logic             den_neg;
  logic             num_pos;
  logic [REM_W-1:0] n_ext;
  logic [REM_W-1:0] d_ext;
  logic [REM_W-1:0] rest_ext;

  function automatic logic [NUM_W-1:0] mean_ext(input logic [MEAN_W-1:0] m);
    return {{(NUM_W-MEAN_W){1'b0}}, m};
  endfunction

  // stage a: numerator and denominator of the fraction
  always_comb begin
    x_ext           = {{(NUM_W-INTENSITY_BITS){1'b0}}, intensity};
    frac_next.valid = in_valid;
    frac_next.cls   = tissue_cls_t'(tissue_class);
    frac_next.num   = '0;
    frac_next.den   = '0;
    case (frac_next.cls)
      CLS_CSF_BG: begin
        frac_next.num = x_ext;
        frac_next.den = {2'b00, cfg.mean_csf};
      end
      CLS_GM_CSF: begin
        frac_next.num = x_ext - mean_ext(cfg.mean_csf);
        frac_next.den = {2'b00, cfg.mean_gm} - {2'b00, cfg.mean_csf};
      end
      CLS_WM_GM: begin
        frac_next.num = x_ext - mean_ext(cfg.mean_gm);
        frac_next.den = {2'b00, cfg.mean_wm} - {2'b00, cfg.mean_gm};
      end
      default: begin
      end
    endcase
  end

  // stage b: fold the sign into the numerator, clamp to n <= d with d >= 1
  always_comb begin
    den_neg        = frac.den[DEN_W-1];
    num_abs        = den_neg ? (NUM_W'(0) - frac.num) : frac.num;
    den_abs        = den_neg ? (DEN_W'(0) - frac.den) : frac.den;
    den_ext        = {{(NUM_W-DEN_W){1'b0}}, den_abs};
    num_pos        = !num_abs[NUM_W-1] && (num_abs != '0);
    mag_next.valid = frac.valid;
    mag_next.cls   = frac.cls;
    mag_next.n     = '0;
    mag_next.d     = MEAN_W'(1);
    if (frac.den == '0) begin
      // zero spread: full weight at or above the lower mean
      mag_next.n = frac.num[NUM_W-1] ? '0 : MEAN_W'(1);
    end else if (!num_pos) begin
      mag_next.n = '0;
    end else if (num_abs >= den_ext) begin
      mag_next.n = MEAN_W'(1);
    end else begin
      mag_next.n = num_abs[MEAN_W-1:0];
      mag_next.d = den_abs[MEAN_W-1:0];
    end
  end

  // stage c: rounded quotients become (510*n + d) / (2*d) and (510*(d-n) + d) / (2*d)
  always_comb begin
    n_ext            = REM_W'(mag.n);
    d_ext            = REM_W'(mag.d);
    rest_ext         = d_ext - n_ext;
    out_next.valid   = mag.valid;
    out_next.cls     = mag.cls;
    out_next.divisor = {mag.d, 1'b0};
    out_next.hi.rem  = n_ext * REM_W'(PAIR_SCALE) + d_ext;
    out_next.hi.quot = '0;
    out_next.lo.rem  = rest_ext * REM_W'(PAIR_SCALE) + d_ext;
    out_next.lo.quot = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frac.valid      <= 1'b0;
      mag.valid       <= 1'b0;
      out_stage.valid <= 1'b0;
    end else if (en) begin
      frac      <= frac_next;
      mag       <= mag_next;
      out_stage <= out_next;
    end
  end

endmodule

// File: rtl/tcp_div_stage.sv
// one restoring divider stage, two quotient bits (BITS_PER_STAGE) for both lanes
module tcp_div_stage import tcp_pkg::*; #(
  parameter int TOP_BIT = PROB_W - 1
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  div_stage_t in_stage,
  output div_stage_t out_stage
);

  div_stage_t stage_next;

  function automatic div_lane_t lane_step(input div_lane_t l, input logic [DIVR_W-1:0] dv);
    div_lane_t        r;
    logic [REM_W:0]   diff;
    logic [REM_W-1:0] shifted;
    r = l;
    for (int j = 0; j < BITS_PER_STAGE; j++) begin
      shifted = REM_W'(dv) << (TOP_BIT - j);
      diff    = {1'b0, r.rem} - {1'b0, shifted};
      if (!diff[REM_W]) begin
        r.rem               = diff[REM_W-1:0];
        r.quot[TOP_BIT - j] = 1'b1;
      end
    end
    return r;
  endfunction

  always_comb begin
    stage_next    = in_stage;
    stage_next.hi = lane_step(in_stage.hi, in_stage.divisor);
    stage_next.lo = lane_step(in_stage.lo, in_stage.divisor);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_stage.valid <= 1'b0;
    end else if (en) begin
      out_stage <= stage_next;
    end
  end

endmodule

// File: rtl/tcp_label.sv
// output stage: map quotients to tissues, argmax label, result register
module tcp_label import tcp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  div_stage_t       in_stage,
  input  logic [OFS_W-1:0] label_offset,
  output result_t          res
);

  result_t           res_next;
  tissue_idx_t       best;
  logic [PROB_W-1:0] best_val;

  always_comb begin
    res_next.valid    = in_stage.valid;
    res_next.csf_prob = '0;
    res_next.gm_prob  = '0;
    res_next.wm_prob  = '0;
    case (in_stage.cls)
      CLS_CSF_BG: res_next.csf_prob = in_stage.hi.quot;
      CLS_CSF:    res_next.csf_prob = PROB_ONE;
      CLS_GM_CSF: begin
        res_next.csf_prob = in_stage.lo.quot;
        res_next.gm_prob  = in_stage.hi.quot;
      end
      CLS_GM:     res_next.gm_prob = PROB_ONE;
      CLS_WM_GM: begin
        res_next.gm_prob = in_stage.lo.quot;
        res_next.wm_prob = in_stage.hi.quot;
      end
      CLS_WM:     res_next.wm_prob = PROB_ONE;
      default: begin
      end
    endcase

    // ties keep the lower index
    best     = IDX_CSF;
    best_val = res_next.csf_prob;
    if (res_next.gm_prob > best_val) begin
      best     = IDX_GM;
      best_val = res_next.gm_prob;
    end
    if (res_next.wm_prob > best_val) begin
      best = IDX_WM;
    end
    res_next.tissue_label = label_offset + OFS_W'(best);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res <= res_next;
    end
  end

endmodule

// File: rtl/tissue_class_to_probabilities_core.sv
// an input transfer reaches the output register through the prep, divider and label stages
// throughput: one voxel per cycle; the 8 register stages advance together and
// hold while the output register is full and not taken
// the quotients come from a 4-stage restoring divider, 2 quotient bits per stage
// reset clears all valid bits and the configuration registers to zero
module tissue_class_to_probabilities_core import tcp_pkg::*; #(
  parameter int INTENSITY_BITS = INTENSITY_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  tcp_in_if.sink           voxel,
  tcp_out_if.source        result
);

  cfg_t       cfg;
  logic       en;
  result_t    res;
  div_stage_t div_pipe [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_MEAN_CSF:  cfg.mean_csf     <= cfg_data;
        REG_MEAN_GM:   cfg.mean_gm      <= cfg_data;
        REG_MEAN_WM:   cfg.mean_wm      <= cfg_data;
        REG_LABEL_OFS: cfg.label_offset <= cfg_data[OFS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // whole pipeline moves unless a finished result is waiting
  assign en          = !res.valid || result.ready;
  assign voxel.ready = en;

  tcp_prep #(
    .INTENSITY_BITS (INTENSITY_BITS)
  ) u_prep (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (voxel.valid),
    .tissue_class (voxel.tissue_class),
    .intensity    (voxel.intensity),
    .cfg          (cfg),
    .out_stage    (div_pipe[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    tcp_div_stage #(
      .TOP_BIT (PROB_W - 1 - g * BITS_PER_STAGE)
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_stage  (div_pipe[g]),
      .out_stage (div_pipe[g+1])
    );
  end

  tcp_label u_label (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_stage     (div_pipe[DIV_STAGES]),
    .label_offset (cfg.label_offset),
    .res          (res)
  );

  assign result.valid        = res.valid;
  assign result.csf_prob     = res.csf_prob;
  assign result.gm_prob      = res.gm_prob;
  assign result.wm_prob      = res.wm_prob;
  assign result.tissue_label = res.tissue_label;

endmodule

// File: rtl/tcp_checker.sv
// port level checks of the core, bound to the top level
`include "assert_macros.svh"

module tcp_checker import tcp_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [PROB_W-1:0] csf_prob,
  input logic [PROB_W-1:0] wm_prob
);

  // a stalled result stays valid and keeps its csf_prob
  `CHK_ON(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(csf_prob), "result changed while stalled")
  // reset empties the output register
  `CHK_ALWAYS(a_rst_empty, rst |=> !out_valid, "result valid right after reset")
  // an empty output register never blocks the input
  `CHK_ON(a_ready_empty, !out_valid |-> in_ready, "input stalled with empty output")
  // no class mixes csf and wm
  `CHK_ON(a_csf_wm_excl, out_valid |-> (csf_prob == '0 || wm_prob == '0), "csf and wm both nonzero")

endmodule

bind tissue_class_to_probabilities_core tcp_checker u_tcp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (voxel.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .csf_prob  (result.csf_prob),
  .wm_prob   (result.wm_prob)
);

// File: tb/sv/tissue_class_to_probabilities_core_tb.sv
// testbench of the tissue class to probabilities core: directed and random voxels, self-checked
module tissue_class_to_probabilities_core_tb;
  import tcp_pkg::*;

  localparam int INTENSITY_BITS = INTENSITY_BITS_DEF;
  localparam int CLK_PERIOD     = 12;
  localparam int PIPE_LATENCY   = 8;
  localparam int MAX_X          = (1 << INTENSITY_BITS) - 1;
  localparam int MEAN_MAX       = (1 << MEAN_W) - 1;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_VOXELS   = 150;
  localparam int MAX_REPORTS    = 50;

  typedef struct packed {
    tissue_cls_t               cls;
    logic [INTENSITY_BITS-1:0] intensity;
  } voxel_t;

  typedef struct packed {
    logic [PROB_W-1:0] csf;
    logic [PROB_W-1:0] gm;
    logic [PROB_W-1:0] wm;
    logic [OFS_W-1:0]  label;
  } prob_set_t;

  // complementary pair of one partial-volume class
  typedef struct packed {
    logic [PROB_W-1:0] lower;
    logic [PROB_W-1:0] upper;
  } pv_split_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  tcp_in_if #(.INTENSITY_BITS(INTENSITY_BITS)) voxel_if ();
  tcp_out_if result_if ();

  tissue_class_to_probabilities_core #(.INTENSITY_BITS(INTENSITY_BITS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .voxel     (voxel_if),
    .result    (result_if)
  );

  // shadow of the configuration registers
  logic [MEAN_W-1:0] cur_mean_csf = '0;
  logic [MEAN_W-1:0] cur_mean_gm  = '0;
  logic [MEAN_W-1:0] cur_mean_wm  = '0;
  logic [OFS_W-1:0]  cur_label_ofs = '0;

  voxel_t    voxel_q[$];
  prob_set_t expected_probs_q[$];
  voxel_t    next_voxel;
  prob_set_t want;
  logic      voxel_taken;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        errors;
  int        voxels_sent;
  int        results_checked;
  int        settings_count;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * 400000);
    $display("FAIL");
    $finish;
  end

  function automatic pv_split_t interpolate_pair(longint num, longint den);
    pv_split_t s;
    longint    n;
    longint    d;
    n = num;
    d = den;
    if (d == 0) begin
      s.lower = (n >= 0) ? '0 : PROB_ONE;
      s.upper = (n >= 0) ? PROB_ONE : '0;
      return s;
    end
    if (d < 0) begin
      d = -d;
      n = -n;
    end
    if (n <= 0) begin
      s.lower = PROB_ONE;
      s.upper = '0;
    end else if (n >= d) begin
      s.lower = '0;
      s.upper = PROB_ONE;
    end else begin
      // each side rounded half up on its own
      s.upper = PROB_W'((PAIR_SCALE * n + d) / (2 * d));
      s.lower = PROB_W'((PAIR_SCALE * (d - n) + d) / (2 * d));
    end
    return s;
  endfunction

  function automatic prob_set_t predict_probabilities(tissue_cls_t cls,
                                                      logic [INTENSITY_BITS-1:0] x);
    prob_set_t         r;
    logic [PROB_W-1:0] p [3];
    pv_split_t         s;
    tissue_idx_t       best;
    longint            xi;
    xi = longint'(x);
    p[IDX_CSF] = '0;
    p[IDX_GM]  = '0;
    p[IDX_WM]  = '0;
    case (cls)
      CLS_CSF_BG: begin
        s = interpolate_pair(xi, longint'(cur_mean_csf));
        p[IDX_CSF] = s.upper;
      end
      CLS_CSF: p[IDX_CSF] = PROB_ONE;
      CLS_GM_CSF: begin
        s = interpolate_pair(xi - longint'(cur_mean_csf),
                             longint'(cur_mean_gm) - longint'(cur_mean_csf));
        p[IDX_CSF] = s.lower;
        p[IDX_GM]  = s.upper;
      end
      CLS_GM: p[IDX_GM] = PROB_ONE;
      CLS_WM_GM: begin
        s = interpolate_pair(xi - longint'(cur_mean_gm),
                             longint'(cur_mean_wm) - longint'(cur_mean_gm));
        p[IDX_GM] = s.lower;
        p[IDX_WM] = s.upper;
      end
      CLS_WM: p[IDX_WM] = PROB_ONE;
      default: ;
    endcase
    // ties go to the lowest index
    best = IDX_CSF;
    if (p[IDX_GM] > p[best]) best = IDX_GM;
    if (p[IDX_WM] > p[best]) best = IDX_WM;
    r.csf   = p[IDX_CSF];
    r.gm    = p[IDX_GM];
    r.wm    = p[IDX_WM];
    r.label = cur_label_ofs + OFS_W'(best);
    return r;
  endfunction

  task automatic check_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
    if (act_val !== exp_val) begin
      if (errors < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                 act_val);
      errors++;
    end
  endtask

  // voxel driver
  always @(negedge clk) begin
    if (rst) begin
      voxel_if.valid <= 1'b0;
    end else if (!voxel_if.valid || voxel_taken) begin
      if (voxel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_voxel = voxel_q.pop_front();
        voxel_if.valid        <= 1'b1;
        voxel_if.tissue_class <= next_voxel.cls;
        voxel_if.intensity    <= next_voxel.intensity;
      end else begin
        voxel_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    if (rst) begin
      voxel_taken <= 1'b0;
    end else begin
      voxel_taken <= voxel_if.valid && voxel_if.ready;
      if (voxel_if.valid && voxel_if.ready) begin
        expected_probs_q.push_back(
          predict_probabilities(tissue_cls_t'(voxel_if.tissue_class), voxel_if.intensity));
        voxels_sent++;
      end
      if (result_if.valid && result_if.ready) begin
        if (expected_probs_q.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d", $time,
                     result_if.csf_prob, result_if.gm_prob, result_if.wm_prob,
                     result_if.tissue_label);
          errors++;
        end else begin
          want = expected_probs_q.pop_front();
          check_field("csf_prob", want.csf, result_if.csf_prob);
          check_field("gm_prob", want.gm, result_if.gm_prob);
          check_field("wm_prob", want.wm, result_if.wm_prob);
          check_field("tissue_label", want.label, result_if.tissue_label);
          results_checked++;
        end
      end
    end
  end

  task automatic set_idling(int mode);
    case (mode)
      0: begin
        send_idle_pct  = 24;
        recv_stall_pct = 70;
      end
      1: begin
        send_idle_pct  = 70;
        recv_stall_pct = 24;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  task automatic add_voxel(tissue_cls_t cls, int x);
    voxel_t v;
    v.cls       = cls;
    v.intensity = INTENSITY_BITS'(x);
    voxel_q.push_back(v);
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (voxel_q.size() != 0 || voxel_if.valid || expected_probs_q.size() != 0);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_MEAN_CSF:  cur_mean_csf  = data[MEAN_W-1:0];
      REG_MEAN_GM:   cur_mean_gm   = data[MEAN_W-1:0];
      REG_MEAN_WM:   cur_mean_wm   = data[MEAN_W-1:0];
      REG_LABEL_OFS: cur_label_ofs = data[OFS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_config(int csf, int gm, int wm, int ofs);
    write_reg(REG_MEAN_CSF, CFG_W'(csf));
    write_reg(REG_MEAN_GM, CFG_W'(gm));
    write_reg(REG_MEAN_WM, CFG_W'(wm));
    // upper data bits are junk for the label offset
    write_reg(REG_LABEL_OFS, {8'($urandom), OFS_W'(ofs)});
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  task automatic random_config();
    int a;
    int b;
    int c;
    case ($urandom_range(5))
      0, 1, 2: begin
        a = $urandom_range(20000);
        b = a + $urandom_range(20000);
        c = b + $urandom_range(25000);
      end
      3: begin
        // narrow gaps make coarse, tie-heavy fractions
        a = $urandom_range(65000);
        b = a + $urandom_range(3);
        c = b + $urandom_range(3);
      end
      4: begin
        a = $urandom_range(MEAN_MAX);
        b = $urandom_range(MEAN_MAX);
        c = $urandom_range(MEAN_MAX);
      end
      default: begin
        a = $urandom_range(1) ? MEAN_MAX : 0;
        b = $urandom_range(1) ? MEAN_MAX : 0;
        c = $urandom_range(1) ? MEAN_MAX : $urandom_range(MEAN_MAX);
      end
    endcase
    write_config(a, b, c, $urandom_range(255));
  endtask

  task automatic add_random_voxel();
    tissue_cls_t cls;
    int          lo;
    int          hi;
    int          tmp;
    int          x;
    cls = tissue_cls_t'($urandom_range(7));
    case (cls)
      CLS_CSF_BG: begin
        lo = 0;
        hi = cur_mean_csf;
      end
      CLS_GM_CSF: begin
        lo = cur_mean_csf;
        hi = cur_mean_gm;
      end
      CLS_WM_GM: begin
        lo = cur_mean_gm;
        hi = cur_mean_wm;
      end
      default: begin
        lo = 0;
        hi = MAX_X;
      end
    endcase
    if (lo > hi) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    case ($urandom_range(9))
      0, 1, 2, 3, 4: x = $urandom_range(hi, lo);
      5, 6: x = ($urandom_range(1) ? lo : hi) + int'($urandom_range(6)) - 3;
      7: x = $urandom_range(MAX_X);
      8: x = $urandom_range(1) ? MAX_X : 0;
      default: x = $urandom_range(1) ? lo : hi;
    endcase
    if (x < 0) x = 0;
    if (x > MAX_X) x = MAX_X;
    add_voxel(cls, x);
  endtask

  initial begin : stimulus
    int ph;
    int k;
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = REG_MEAN_CSF;
    cfg_data              = '0;
    voxel_if.valid        = 1'b0;
    voxel_if.tissue_class = CLS_BG;
    voxel_if.intensity    = '0;
    result_if.ready       = 1'b0;
    errors                = 0;
    voxels_sent           = 0;
    results_checked       = 0;
    settings_count        = 1;
    set_idling(0);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // registers at reset: every class, zero denominator of the csf-bg class
    for (k = 0; k < 8; k++) add_voxel(tissue_cls_t'(k), MAX_X);
    add_voxel(CLS_CSF_BG, 0);
    wait_drained();

    // exact halves round up on both sides; labels near the top of the offset
    write_config(1000, 1002, 5000, 253);
    add_voxel(CLS_CSF_BG, 500);
    add_voxel(CLS_GM_CSF, 1001);
    add_voxel(CLS_WM_GM, 3001);
    add_voxel(CLS_WM_GM, MAX_X);
    add_voxel(CLS_GM_CSF, 0);
    add_voxel(CLS_WM, 0);
    add_voxel(CLS_GM, 1234);
    add_voxel(CLS_CSF, 1);
    wait_drained();

    // falling means give negative denominators; label wraps past 255
    write_config(MEAN_MAX, 30000, 0, 255);
    add_voxel(CLS_GM_CSF, 40000);
    add_voxel(CLS_WM_GM, 10000);
    add_voxel(CLS_WM, 7);
    add_voxel(CLS_CSF_BG, MAX_X);
    wait_drained();

    // equal means: zero denominators just below and at the lower mean
    write_config(40000, 40000, 40000, 0);
    add_voxel(CLS_GM_CSF, 39999);
    add_voxel(CLS_GM_CSF, 40000);
    add_voxel(CLS_WM_GM, 39999);
    add_voxel(CLS_WM_GM, 40000);
    wait_drained();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_idling(ph / 4);
      random_config();
      for (k = 0; k < PHASE_VOXELS; k++) add_random_voxel();
      wait_drained();
    end

    $display("sent %0d voxels over %0d register settings, %0d results checked",
             voxels_sent, settings_count, results_checked);
    $display("idling: sender-light, receiver-light and back-to-back phases");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/tcp_pkg.sv
rtl/tcp_stream_if.sv
rtl/tcp_prep.sv
rtl/tcp_div_stage.sv
rtl/tcp_label.sv
rtl/tissue_class_to_probabilities_core.sv
rtl/tcp_checker.sv
tb/sv/tissue_class_to_probabilities_core_tb.sv
